FILE: sv/rgb_box_average_downscaler_defines.svh
// assertion macros for the rgb box average downscaler
// used by the top level only, relies on clk_i and rst_ni in scope
`ifndef RGB_BOX_AVERAGE_DOWNSCALER_DEFINES_SVH
`define RGB_BOX_AVERAGE_DOWNSCALER_DEFINES_SVH

// property that must hold in the same cycle
`define RBAD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// property that must hold in the cycle after the antecedent
`define RBAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rbad_pkg.sv
// shared types and constants of the rgb box average downscaler
// no dependencies
`default_nettype none

package rbad_pkg;

  localparam int PixW     = 16;
  localparam int RowW     = 12;
  localparam int HeightLimit = 4096;
  localparam int CfgDW    = 13;
  localparam int CfgIW    = 2;

  localparam logic [CfgIW-1:0] CfgScale  = 2'd0;
  localparam logic [CfgIW-1:0] CfgWidth  = 2'd1;
  localparam logic [CfgIW-1:0] CfgHeight = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic clear;
    logic rd;
    logic acc;
    logic load_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pos_busy;
    logic sum_busy;
    logic clear_last;
    logic emit;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: sv/rbad_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module rbad_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/rbad_div.sv
// iterative restoring divider, one quotient bit per cycle
// no dependencies
`default_nettype none

module rbad_div #(
  parameter int NW = 12,
  parameter int DW = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               busy_o,
  output logic      [NW-1:0] quot_o,
  output logic      [DW-1:0] rem_o
);

  localparam int CntW = $clog2(NW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NW-1:0]   q_q, q_d;
  logic [DW-1:0]   r_q, r_d;
  logic [DW-1:0]   d_q, d_d;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            ge;

  // one restoring step
  always_comb begin
    trial = {r_q, q_q[NW-1]};
    ge    = trial >= {1'b0, d_q};
    diff  = trial - {1'b0, d_q};
    cnt_d = cnt_q;
    q_d   = q_q;
    r_d   = r_q;
    d_d   = d_q;
    if (start_i) begin
      cnt_d = CntW'(NW);
      q_d   = dividend_i;
      r_d   = '0;
      d_d   = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      q_d   = {q_q[NW-2:0], ge};
      r_d   = ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    d_q <= d_d;
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

`default_nettype wire

FILE: sv/rbad_dp.sv
// datapath: config registers, position counters, dividers, column sum ram, output register
// depends on rbad_pkg, rbad_div, rbad_ram
`default_nettype none

module rbad_dp #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_FACTOR = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rbad_pkg::CfgIW-1:0]    cfg_index_i,
  input  wire logic [rbad_pkg::CfgDW-1:0]    cfg_data_i,
  input  wire logic                          frame_start_i,
  input  wire logic [rbad_pkg::PixW-1:0]     red_in_i,
  input  wire logic [rbad_pkg::PixW-1:0]     green_in_i,
  input  wire logic [rbad_pkg::PixW-1:0]     blue_in_i,
  input  wire rbad_pkg::cmd_t                cmd_i,
  output rbad_pkg::status_t                  status_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic      [rbad_pkg::PixW-1:0]     red_avg_o,
  output logic      [rbad_pkg::PixW-1:0]     green_avg_o,
  output logic      [rbad_pkg::PixW-1:0]     blue_avg_o,
  output logic                               last_in_frame_o
);

  localparam int PW  = rbad_pkg::PixW;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int FW  = $clog2(MAX_FACTOR + 1);
  localparam int AW  = 2 * FW;
  localparam int SW  = PW + 2 * $clog2(MAX_FACTOR) + 2;
  localparam int RW  = rbad_pkg::RowW;
  localparam int HW  = RW + 1;
  localparam int PCW = CW + FW + 2;
  localparam int PRW = RW + FW + 2;

  // config registers
  logic [4:0]                 sf_q;
  logic [rbad_pkg::CfgDW-1:0] fw_q, fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_q <= 5'd1;
      fw_q <= 13'd4096;
      fh_q <= 13'd4096;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rbad_pkg::CfgScale:  sf_q <= cfg_data_i[4:0];
        rbad_pkg::CfgWidth:  fw_q <= cfg_data_i;
        rbad_pkg::CfgHeight: fh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped settings
  logic [FW-1:0] f_eff;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [AW-1:0] area;

  always_comb begin
    if (sf_q == '0) begin
      f_eff = FW'(1);
    end else if (int'(sf_q) > MAX_FACTOR) begin
      f_eff = FW'(MAX_FACTOR);
    end else begin
      f_eff = FW'(sf_q);
    end
    if (fw_q == '0) begin
      w_eff = WW'(1);
    end else if (int'(fw_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_q);
    end
    if (fh_q == '0) begin
      h_eff = HW'(1);
    end else if (int'(fh_q) > rbad_pkg::HeightLimit) begin
      h_eff = HW'(rbad_pkg::HeightLimit);
    end else begin
      h_eff = HW'(fh_q);
    end
  end

  assign area = AW'(f_eff) * AW'(f_eff);

  // position and pixel registers
  logic [CW-1:0] col_q, col_start;
  logic [RW-1:0] row_q, row_start;
  logic [PW-1:0] pr_q, pg_q, pb_q;
  logic [CW:0]   col_next;
  logic [HW-1:0] row_next;

  assign col_start = frame_start_i ? '0 : col_q;
  assign row_start = frame_start_i ? '0 : row_q;
  assign col_next  = {1'b0, col_q} + 1'b1;
  assign row_next  = {1'b0, row_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.accept) begin
      col_q <= col_start;
      row_q <= row_start;
    end else if (cmd_i.acc) begin
      if (col_next >= (CW + 1)'(w_eff)) begin
        col_q <= '0;
        row_q <= (row_next >= h_eff) ? '0 : row_next[RW-1:0];
      end else begin
        col_q <= col_next[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pr_q <= red_in_i;
      pg_q <= green_in_i;
      pb_q <= blue_in_i;
    end
  end

  // position split into block index and offset
  logic [CW-1:0] qc;
  logic [FW-1:0] rc;
  logic [RW-1:0] qr;
  logic [FW-1:0] rr;
  logic          busy_c, busy_r;

  rbad_div #(.NW(CW), .DW(FW)) u_div_col (
    .clk_i, .rst_ni, .start_i(cmd_i.accept), .dividend_i(col_start), .divisor_i(f_eff),
    .busy_o(busy_c), .quot_o(qc), .rem_o(rc)
  );

  rbad_div #(.NW(RW), .DW(FW)) u_div_row (
    .clk_i, .rst_ni, .start_i(cmd_i.accept), .dividend_i(row_start), .divisor_i(f_eff),
    .busy_o(busy_r), .quot_o(qr), .rem_o(rr)
  );

  // block range and corner checks
  logic [PCW-1:0] colp;
  logic [PRW-1:0] rowp;
  logic [FW-1:0]  f_m1;
  logic           inr_q, load_q, emit_q, last_q;

  assign colp = (PCW'(qc) + 1'b1) * PCW'(f_eff);
  assign rowp = (PRW'(qr) + 1'b1) * PRW'(f_eff);
  assign f_m1 = f_eff - 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      inr_q  <= (colp <= PCW'(w_eff)) && (rowp <= PRW'(h_eff));
      load_q <= (rc == '0) && (rr == '0);
      emit_q <= (rc == f_m1) && (rr == f_m1);
      last_q <= ((colp + PCW'(f_eff)) > PCW'(w_eff)) &&
                ((rowp + PRW'(f_eff)) > PRW'(h_eff));
    end
  end

  // clearing sweep address
  logic [CW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // column sum ram
  logic [3*SW-1:0] rdata, wdata;
  logic            we;
  logic [CW-1:0]   waddr;
  logic [SW-1:0]   sum_r, sum_g, sum_b;

  always_comb begin
    if (load_q) begin
      sum_r = SW'(pr_q);
      sum_g = SW'(pg_q);
      sum_b = SW'(pb_q);
    end else begin
      sum_r = rdata[3*SW-1:2*SW] + SW'(pr_q);
      sum_g = rdata[2*SW-1:SW] + SW'(pg_q);
      sum_b = rdata[SW-1:0] + SW'(pb_q);
    end
  end

  assign we    = cmd_i.clear || (cmd_i.acc && inr_q);
  assign waddr = cmd_i.clear ? clr_q : qc;
  assign wdata = cmd_i.clear ? '0 : {sum_r, sum_g, sum_b};

  rbad_ram #(.Width(3 * SW), .Depth(MAX_WIDTH)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(cmd_i.rd), .raddr_i(qc), .rdata_o(rdata)
  );

  // averages by division through block area
  logic          sum_start;
  logic          busy_sr, busy_sg, busy_sb;
  logic [SW-1:0] avg_r, avg_g, avg_b;

  assign sum_start = cmd_i.acc && inr_q && emit_q;

  rbad_div #(.NW(SW), .DW(AW)) u_div_red (
    .clk_i, .rst_ni, .start_i(sum_start), .dividend_i(sum_r), .divisor_i(area),
    .busy_o(busy_sr), .quot_o(avg_r), .rem_o()
  );

  rbad_div #(.NW(SW), .DW(AW)) u_div_green (
    .clk_i, .rst_ni, .start_i(sum_start), .dividend_i(sum_g), .divisor_i(area),
    .busy_o(busy_sg), .quot_o(avg_g), .rem_o()
  );

  rbad_div #(.NW(SW), .DW(AW)) u_div_blue (
    .clk_i, .rst_ni, .start_i(sum_start), .dividend_i(sum_b), .divisor_i(area),
    .busy_o(busy_sb), .quot_o(avg_b), .rem_o()
  );

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      red_avg_o       <= avg_r[PW-1:0];
      green_avg_o     <= avg_g[PW-1:0];
      blue_avg_o      <= avg_b[PW-1:0];
      last_in_frame_o <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // status back to the controller
  assign status_o.pos_busy   = busy_c || busy_r;
  assign status_o.sum_busy   = busy_sr || busy_sg || busy_sb;
  assign status_o.clear_last = clr_q == CW'(MAX_WIDTH - 1);
  assign status_o.emit       = inr_q && emit_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

FILE: sv/rbad_ctrl.sv
// controller state machine sequencing one pixel item at a time
// depends on rbad_pkg
`default_nettype none

module rbad_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rbad_pkg::status_t status_i,
  output rbad_pkg::cmd_t         cmd_o
);

  typedef enum logic [6:0] {
    StClear  = 7'b0000001,
    StIdle   = 7'b0000010,
    StPosDiv = 7'b0000100,
    StRead   = 7'b0001000,
    StAcc    = 7'b0010000,
    StSumDiv = 7'b0100000,
    StOut    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StClear: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) state_d = StIdle;
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = StPosDiv;
        end
      end
      StPosDiv: begin
        if (!status_i.pos_busy) state_d = StRead;
      end
      StRead: begin
        cmd_o.rd = 1'b1;
        state_d = StAcc;
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
        state_d = status_i.emit ? StSumDiv : StIdle;
      end
      StSumDiv: begin
        if (!status_i.sum_busy) state_d = StOut;
      end
      StOut: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rgb_box_average_downscaler.sv
// rgb box average downscaler top level: one item at a time.
// each item is accepted, its position split bit-serially into block index and offset,
// then its column sum is read and, inside the used area, updated.
// an item that closes a block then waits for the three average dividers and one
// output load; the result waits in a register until it is taken.
// after reset the column sum ram is swept to zero, input not ready.
`default_nettype none
`include "rgb_box_average_downscaler_defines.svh"

module rgb_box_average_downscaler #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_FACTOR = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [rbad_pkg::CfgIW-1:0] cfg_index_i,
  input  wire logic [rbad_pkg::CfgDW-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       frame_start_i,
  input  wire logic [rbad_pkg::PixW-1:0]  red_in_i,
  input  wire logic [rbad_pkg::PixW-1:0]  green_in_i,
  input  wire logic [rbad_pkg::PixW-1:0]  blue_in_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [rbad_pkg::PixW-1:0]  red_avg_o,
  output logic      [rbad_pkg::PixW-1:0]  green_avg_o,
  output logic      [rbad_pkg::PixW-1:0]  blue_avg_o,
  output logic                            last_in_frame_o
);

  rbad_pkg::cmd_t    cmd;
  rbad_pkg::status_t status;

  rbad_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .status_i(status), .cmd_o(cmd)
  );

  rbad_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_FACTOR(MAX_FACTOR)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .frame_start_i, .red_in_i, .green_in_i, .blue_in_i,
    .cmd_i(cmd), .status_o(status), .out_ready_i, .out_valid_o,
    .red_avg_o, .green_avg_o, .blue_avg_o, .last_in_frame_o
  );

  // checks
  `RBAD_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `RBAD_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd), "commands overlap")
  `RBAD_ASSERT_NOW(a_no_take_while_div, status.sum_busy || status.pos_busy, !in_ready_o, "ready while dividing")

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// self-checking bench for the rgb box average downscaler
// depends on rbad_pkg and rgb_box_average_downscaler, no other files
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

  localparam int IdxW  = rbad_pkg::CfgIW;
  localparam int DataW = rbad_pkg::CfgDW;
  localparam int PixW  = rbad_pkg::PixW;

  typedef struct {
    bit        fs;
    bit [15:0] r, g, b;
  } pixel_t;

  typedef struct {
    bit [15:0] r, g, b;
    bit        last;
  } block_avg_t;

  localparam int NumPixels  = 600;
  localparam int CycleLimit = 1000000;
  localparam int IdleWait   = 80;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [IdxW-1:0]     cfg_index_i = '0;
  logic [DataW-1:0]    cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                frame_start_i = 1'b0;
  logic [PixW-1:0]     red_in_i = '0, green_in_i = '0, blue_in_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [PixW-1:0]     red_avg_o, green_avg_o, blue_avg_o;
  logic                last_in_frame_o;

  rgb_box_average_downscaler dut (.*);

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  bit [4:0]    scale_reg = 5'd1;
  bit [12:0]   width_reg = 13'd4096, height_reg = 13'd4096;
  bit [31:0]   red_sums[4096], green_sums[4096], blue_sums[4096];
  bit [31:0]   col_pos, row_pos;
  pixel_t      pixel_q[$];
  block_avg_t  avg_q[$];
  int          errors;
  int          cycles;
  int          pixels_sent;
  bit          in_taken;

  function automatic bit [31:0] clamp_to(bit [31:0] v, bit [31:0] hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // box average prediction of one accepted pixel
  function automatic void predict_block(pixel_t p);
    bit [31:0] f, w, h, used_w, used_h, c, rw, idx, cx, ry, area;
    block_avg_t e;
    f = clamp_to(scale_reg, 16);
    w = clamp_to(width_reg, 4096);
    h = clamp_to(height_reg, 4096);
    used_w = (w / f) * f;
    used_h = (h / f) * f;
    if (p.fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    rw = row_pos;
    if (c < used_w && rw < used_h) begin
      idx = c / f;
      cx = c % f;
      ry = rw % f;
      if (cx == 0 && ry == 0) begin
        red_sums[idx] = p.r;
        green_sums[idx] = p.g;
        blue_sums[idx] = p.b;
      end else begin
        red_sums[idx] += p.r;
        green_sums[idx] += p.g;
        blue_sums[idx] += p.b;
      end
      if (cx == f - 1 && ry == f - 1) begin
        area = f * f;
        e.r = 16'(red_sums[idx] / area);
        e.g = 16'(green_sums[idx] / area);
        e.b = 16'(blue_sums[idx] / area);
        e.last = (c == used_w - 1 && rw == used_h - 1);
        avg_q.push_back(e);
      end
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = rw + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // sender: bursts with random gaps
  int burst_left, gap_left;
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        pixel_t p;
        p = pixel_q.pop_front();
        in_valid_i <= 1'b1;
        frame_start_i <= p.fs;
        red_in_i <= p.r;
        green_in_i <= p.g;
        blue_in_i <= p.b;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall pattern chosen at random from four modes
  int stall_mode;
  always @(negedge clk_i) begin
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (cycles % 16) < 8;
    endcase
  end

  // monitor: predict on input accept, check on output accept
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      pixel_t p;
      p.fs = frame_start_i;
      p.r = red_in_i;
      p.g = green_in_i;
      p.b = blue_in_i;
      predict_block(p);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (avg_q.size() == 0) begin
        report_mismatch("unexpected item", red_avg_o, 0);
      end else begin
        block_avg_t e;
        e = avg_q.pop_front();
        if (red_avg_o !== e.r) report_mismatch("red_avg", red_avg_o, e.r);
        if (green_avg_o !== e.g) report_mismatch("green_avg", green_avg_o, e.g);
        if (blue_avg_o !== e.b) report_mismatch("blue_avg", blue_avg_o, e.b);
        if (last_in_frame_o !== e.last)
          report_mismatch("last_in_frame", last_in_frame_o, e.last);
      end
    end
  end

  function automatic bit [15:0] chan_value();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_pixel(bit fs, bit [15:0] r, bit [15:0] g, bit [15:0] b);
    pixel_t p;
    p.fs = fs;
    p.r = r;
    p.g = g;
    p.b = b;
    pixel_q.push_back(p);
    pixels_sent++;
  endtask

  // wait until sender and block are both idle
  task automatic wait_idle();
    wait (pixel_q.size() == 0);
    @(posedge clk_i);
    wait (!in_valid_i);
    wait (avg_q.size() == 0);
    repeat (IdleWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IdxW-1:0] idx, logic [DataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      rbad_pkg::CfgScale:  scale_reg = val[4:0];
      rbad_pkg::CfgWidth:  width_reg = val;
      rbad_pkg::CfgHeight: height_reg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_geometry(int f, int w, int h);
    wait_idle();
    write_reg(rbad_pkg::CfgScale, DataW'(f));
    write_reg(rbad_pkg::CfgWidth, DataW'(w));
    write_reg(rbad_pkg::CfgHeight, DataW'(h));
  endtask

  // stimulus
  initial begin
    int f, w, h, we, he, frames, n, k;
    bit ok16;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset geometry, factor one: every pixel is its own block
    queue_pixel(1, 16'h0000, 16'hffff, 16'h0000);
    queue_pixel(0, 16'hffff, 16'h0000, 16'hffff);
    queue_pixel(0, 16'haaaa, 16'h5555, 16'haaaa);
    queue_pixel(0, 16'h5555, 16'haaaa, 16'h5555);
    // zero factor and zero frame size read as one: every item ends a frame
    set_geometry(0, 0, 0);
    queue_pixel(1, 16'h1234, 16'hffff, 16'h0001);
    queue_pixel(0, 16'hfffe, 16'h8000, 16'h7fff);
    // oversized settings saturate, far from any block end
    set_geometry(31, 8191, 8191);
    for (int i = 0; i < 4; i++) queue_pixel(i == 0, 16'hffff, 16'hffff, 16'hffff);
    // frame narrower than one block
    set_geometry(4, 3, 8);
    for (int i = 0; i < 6; i++) queue_pixel(i == 0, chan_value(), chan_value(), chan_value());
    // 2x2 blocks over 5x3, partial column and row ignored
    set_geometry(2, 5, 3);
    for (int i = 0; i < 8; i++) queue_pixel(i == 0, 16'hffff, 16'hffff, 16'hffff);

    // random phases
    ok16 = 0;
    while (pixels_sent < NumPixels) begin
      k = $urandom_range(0, 19);
      if (!ok16 && pixels_sent > NumPixels / 3) begin
        f = 16; w = $urandom_range(16, 20); h = 16; ok16 = 1;
      end else if (k == 0) begin
        f = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
        w = $urandom_range(1, 6); h = $urandom_range(1, 4);
      end else begin
        f = $urandom_range(1, 4);
        w = $urandom_range(1, 12); h = $urandom_range(1, 8);
        if (k == 1) w = 0;
        if (k == 2) h = 0;
      end
      set_geometry(f, w, h);
      we = clamp_to(w, 4096);
      he = clamp_to(h, 4096);
      frames = $urandom_range(1, 3);
      for (int fr = 0; fr < frames; fr++) begin
        n = we * he;
        // broken frames now and then: cut short, missing the start marker or with a stray one
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
        for (int i = 0; i < n; i++)
          queue_pixel((i == 0 && $urandom_range(0, 9) != 0) || $urandom_range(0, 49) == 0,
                      chan_value(), chan_value(), chan_value());
      end
    end

    // drain
    wait_idle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
